// ----- sv/cfa_pkg.sv -----
// cfa_pkg: shared widths, codes and types of the contiguous fit allocator
// no dependencies; imported by the interfaces, the fit tracker and the top level
package cfa_pkg;

	localparam int CELLS    = 1024;
	localparam int ADDR_W   = $clog2(CELLS);
	localparam int CNT_W    = $clog2(CELLS + 1);

	localparam int OWNER_W  = 16;
	localparam int SIZE_W   = 11;
	localparam int STATUS_W = 2;
	localparam int START_W  = 10;
	localparam int FREED_W  = 11;
	localparam int MODE_W   = 2;
	localparam int LEN_W    = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;

	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;
	localparam int REGSEL_W = PADDR_W - 2;

	localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);

	localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOFIT  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;

	localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_CLEAR = 1'b1;

	localparam logic [REGSEL_W-1:0] REG_FIT_MODE = 1'b0;

	typedef logic [OWNER_W-1:0] owner_t;
	typedef logic [ADDR_W-1:0]  addr_t;
	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [LEN_W-1:0]   len_t;

	typedef struct packed {
		logic  init;
		logic  cell_vld;
		logic  cell_free;
		logic  cell_last;
		addr_t cell_idx;
	} scan_ctl_t;

	typedef struct packed {
		logic  found;
		addr_t start;
	} fit_res_t;

endpackage

// ----- sv/cfa_req_if.sv -----
// cfa_req_if: request channel of the allocator (valid, ready, request fields)
// depends on cfa_pkg for the field widths
interface cfa_req_if import cfa_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                action;
	logic [OWNER_W-1:0]  owner_id;
	logic [SIZE_W-1:0]   request_size;

	modport source (output valid, output action, output owner_id, output request_size,
		input ready);
	modport sink (input valid, input action, input owner_id, input request_size,
		output ready);
endinterface

// ----- sv/cfa_rsp_if.sv -----
// cfa_rsp_if: result channel of the allocator (valid, ready, result fields)
// depends on cfa_pkg for the field widths
interface cfa_rsp_if import cfa_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [START_W-1:0]  grant_start;
	logic [FREED_W-1:0]  freed_cells;

	modport source (output valid, output status, output grant_start, output freed_cells,
		input ready);
	modport sink (input valid, input status, input grant_start, input freed_cells,
		output ready);
endinterface

// ----- sv/cfa_ram.sv -----
// cfa_ram: generic single-write, single-read ram with registered read data
// no dependencies
module cfa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- sv/cfa_fit_track.sv -----
// cfa_fit_track: follows free runs over the cell stream of one scan and keeps
// the chosen run for first, best or worst fit; depends on cfa_pkg
module cfa_fit_track import cfa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  scan_ctl_t         ctl,
	input  logic [MODE_W-1:0] mode,
	input  len_t              size,
	output fit_res_t          fit
);

	cnt_t  run_q;
	addr_t run_start_q;
	logic  have_q;
	cnt_t  best_len_q;
	addr_t best_start_q;

	logic  ranked;
	logic  worst;
	cnt_t  run_inc;
	cnt_t  run_next;
	logic  run_ev;
	cnt_t  cand_len;
	addr_t cand_start;
	logic  take;
	addr_t take_start;

	always_comb begin
		ranked     = (mode == MODE_BEST) || (mode == MODE_WORST);
		worst      = (mode == MODE_WORST);
		run_inc    = run_q + cnt_t'(1);
		run_next   = ctl.cell_free ? run_inc : '0;
		run_ev     = 1'b0;
		cand_len   = run_q;
		cand_start = run_start_q;
		if (!ctl.cell_free && run_q != '0) begin
			run_ev = 1'b1;
		end else if (ctl.cell_free && ctl.cell_last) begin
			run_ev     = 1'b1;
			cand_len   = run_inc;
			cand_start = (run_q == '0) ? ctl.cell_idx : run_start_q;
		end
		take       = 1'b0;
		take_start = cand_start;
		if (ranked) begin
			if (run_ev) begin
				if (worst) begin
					take = len_t'(cand_len) > len_t'(best_len_q);
				end else begin
					take = (len_t'(cand_len) >= size) && (!have_q || cand_len < best_len_q);
				end
			end
		end else begin
			take       = ctl.cell_free && !have_q && (len_t'(run_inc) == size);
			take_start = ctl.cell_idx - addr_t'(size - len_t'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q       <= '0;
			have_q      <= 1'b0;
			best_len_q  <= '0;
		end else if (ctl.init) begin
			run_q       <= '0;
			have_q      <= 1'b0;
			best_len_q  <= '0;
		end else if (ctl.cell_vld) begin
			run_q <= run_next;
			if (take) begin
				have_q     <= 1'b1;
				best_len_q <= cand_len;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.cell_vld) begin
			if (ctl.cell_free && run_q == '0) begin
				run_start_q <= ctl.cell_idx;
			end
			if (take) begin
				best_start_q <= take_start;
			end
		end
	end

	assign fit.found = ranked ? (have_q && len_t'(best_len_q) >= size) : have_q;
	assign fit.start = best_start_q;

endmodule

// ----- sv/contiguous_fit_allocator_unit.sv -----
// contiguous_fit_allocator_unit: top level with request control, the owner map
// ram and the apb register; depends on cfa_pkg, cfa_req_if, cfa_rsp_if, cfa_ram, cfa_fit_track

// After reset the block writes every cell of the owner map free and takes no request
// until that pass is done; register writes are taken at any time.
// A request is then handled one at a time, paced by the single read port of the map: an
// allocate reads all CELLS cells once, picks the run, writes request_size cells and loads
// the result (it skips the write when no run fits); a clear frees cells while it reads them
// and then loads the result; a rejected request loads its result without any scan.
// The result waits in an output register, and the next request is taken meanwhile.
module contiguous_fit_allocator_unit import cfa_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	cfa_req_if.sink             req,
	cfa_rsp_if.source           rsp,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready
);

	typedef enum logic [5:0] {
		S_INIT = 6'b000001,
		S_IDLE = 6'b000010,
		S_SCAN = 6'b000100,
		S_PICK = 6'b001000,
		S_FILL = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	state_t              state_q;
	logic [MODE_W-1:0]   fit_mode_q;
	addr_t               idx_q;
	logic                issue_q;
	logic                vld_s1;
	addr_t               idx_s1;
	logic                act_q;
	owner_t              owner_q;
	len_t                size_q;
	addr_t               wr_ptr_q;
	len_t                wr_left_q;
	logic [STATUS_W-1:0] status_q;
	addr_t               start_q;
	cnt_t                freed_q;
	logic                rsp_vld_q;
	logic [STATUS_W-1:0] rsp_status_q;
	logic [START_W-1:0]  rsp_start_q;
	logic [FREED_W-1:0]  rsp_freed_q;

	logic      req_acc;
	logic      req_bad;
	logic      rsp_load;
	logic      ram_we;
	addr_t     ram_waddr;
	owner_t    ram_wdata;
	logic      ram_re;
	owner_t    ram_rdata;
	logic      cell_hit;
	logic      scan_end;
	scan_ctl_t scan_ctl;
	fit_res_t  fit;

	// register port
	assign pready = 1'b1;
	assign prdata = (paddr[PADDR_W-1:2] == REG_FIT_MODE) ? PDATA_W'(fit_mode_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q <= MODE_FIRST;
		end else if (psel && penable && pwrite && pready
			&& paddr[PADDR_W-1:2] == REG_FIT_MODE) begin
			fit_mode_q <= pwdata[MODE_W-1:0];
		end
	end

	assign req.ready = (state_q == S_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign req_bad   = (req.owner_id == '0)
		|| (req.action == ACT_ALLOC && req.request_size == '0);
	assign rsp_load  = (state_q == S_DONE) && (!rsp_vld_q || rsp.ready);

	assign cell_hit  = (state_q == S_SCAN) && vld_s1 && act_q == ACT_CLEAR
		&& ram_rdata == owner_q;
	assign scan_end  = (state_q == S_SCAN) && vld_s1 && idx_s1 == LAST_CELL;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wr_ptr_q;
		ram_wdata = '0;
		case (state_q)
			S_INIT: begin
				ram_we = 1'b1;
			end
			S_SCAN: begin
				ram_we    = cell_hit;
				ram_waddr = idx_s1;
			end
			S_FILL: begin
				ram_we    = 1'b1;
				ram_wdata = owner_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	assign ram_re = (state_q == S_SCAN) && issue_q;

	cfa_ram #(
		.WIDTH (OWNER_W),
		.DEPTH (CELLS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	assign scan_ctl.init      = req_acc;
	assign scan_ctl.cell_vld  = (state_q == S_SCAN) && vld_s1 && act_q == ACT_ALLOC;
	assign scan_ctl.cell_free = (ram_rdata == '0);
	assign scan_ctl.cell_last = (idx_s1 == LAST_CELL);
	assign scan_ctl.cell_idx  = idx_s1;

	cfa_fit_track u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (scan_ctl),
		.mode   (fit_mode_q),
		.size   (size_q),
		.fit    (fit)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_INIT;
			wr_ptr_q  <= '0;
			issue_q   <= 1'b0;
			vld_s1    <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			vld_s1 <= ram_re;
			if (rsp_load) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					wr_ptr_q <= wr_ptr_q + addr_t'(1);
					if (wr_ptr_q == LAST_CELL) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_acc) begin
						if (req_bad) begin
							state_q <= S_DONE;
						end else begin
							issue_q <= 1'b1;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (issue_q && idx_q == LAST_CELL) begin
						issue_q <= 1'b0;
					end
					if (scan_end) begin
						state_q <= (act_q == ACT_CLEAR) ? S_DONE : S_PICK;
					end
				end
				S_PICK: begin
					wr_ptr_q <= fit.start;
					state_q  <= fit.found ? S_FILL : S_DONE;
				end
				S_FILL: begin
					wr_ptr_q <= wr_ptr_q + addr_t'(1);
					if (wr_left_q == len_t'(1)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request payload and result bookkeeping
	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		if (ram_re) begin
			idx_q <= idx_q + addr_t'(1);
		end
		if (req_acc) begin
			act_q    <= req.action;
			owner_q  <= req.owner_id;
			size_q   <= len_t'(req.request_size);
			idx_q    <= '0;
			start_q  <= '0;
			freed_q  <= '0;
			status_q <= req_bad ? ST_REJECT : ST_DONE;
		end
		if (cell_hit) begin
			freed_q <= freed_q + cnt_t'(1);
		end
		if (state_q == S_PICK) begin
			wr_left_q <= size_q;
			if (fit.found) begin
				start_q <= fit.start;
			end else begin
				status_q <= ST_NOFIT;
			end
		end
		if (state_q == S_FILL) begin
			wr_left_q <= wr_left_q - len_t'(1);
		end
		if (rsp_load) begin
			rsp_status_q <= status_q;
			rsp_start_q  <= START_W'(start_q);
			rsp_freed_q  <= FREED_W'(freed_q);
		end
	end

	assign rsp.valid       = rsp_vld_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.grant_start = rsp_start_q;
	assign rsp.freed_cells = rsp_freed_q;

	// read and write of the map never meet on one cell
	a_no_rw_same: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && ram_re |-> ram_waddr != idx_q)
		else $error("map read and write hit the same cell");

	// a granted run lies inside the map
	a_run_inside: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PICK && fit.found
		|-> (LEN_W+1)'(fit.start) + (LEN_W+1)'(size_q) <= (LEN_W+1)'(CELLS))
		else $error("granted run runs past the last cell");

	// fill never starts or continues with nothing left to write
	a_fill_left: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FILL |-> wr_left_q != '0)
		else $error("fill with zero cells left");

	// a scan reaches its last cell only after the read of that cell
	a_scan_order: assert property (@(posedge clk) disable iff (!arst_n)
		scan_end |-> $past(ram_re) && !issue_q)
		else $error("scan ended without reading the last cell");

endmodule
